FILE: sv/gcbi_pkg.sv
`default_nettype none
package gcbi_pkg;

   localparam int MAX_GRID_POINTS = 1024;
   localparam int NUM_BANDS       = 6;
   localparam int NUM_KINDS       = 6;
   localparam int PER_POINT       = NUM_BANDS * NUM_KINDS;
   localparam int COEF_DEPTH      = MAX_GRID_POINTS * PER_POINT;
   localparam int GRID_AW         = $clog2(MAX_GRID_POINTS);
   localparam int COEF_AW         = $clog2(COEF_DEPTH);
   localparam int ENTRY_W         = $clog2(PER_POINT);

   typedef struct packed {
      logic        mode;
      logic [9:0]  grid_index;
      logic [2:0]  band;
      logic [2:0]  kind;
      logic [31:0] coef_value;
      logic        point_valid;
      logic [15:0] pixel_line;
      logic [15:0] pixel_sample;
   } req_type;

   typedef struct packed {
      logic [2:0]  out_band;
      logic [2:0]  out_kind;
      logic [31:0] interp_value;
      logic [2:0]  valid_corners;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [10:0] grid_lines;
      logic [10:0] grid_samples;
      logic [11:0] region_lines;
      logic [11:0] region_samples;
   } cfg_type;

   typedef struct packed {
      logic               clear;
      logic [GRID_AW-1:0] clr_addr;
      logic               capture;
      logic               load;
      logic               div_step;
      logic               locate;
      logic               wgt;
      logic               wgt2;
      logic               flag_rd;
      logic               flag_col;
      logic [1:0]         corner;
      logic               acc_clr;
      logic               acc_rd;
      logic [ENTRY_W-1:0] entry;
      logic               fin;
      logic               prep;
      logic               qdiv_step;
      logic               qend;
      logic               emit;
      logic [2:0]         band;
      logic [2:0]         kind;
      logic               last;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic need_div;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: sv/grid_coef_bilinear_interp.sv
// Query beat: a grid position divide, then for each result the four corner reads; when
// zero or four corners are valid no further divide is needed, while with one to three
// valid corners and a nonzero weight sum each result adds a bit-serial divide.
// Results leave through one output register; a query holds the input until done.
// Reset is synchronous: config returns to 32/32/40/40 and a pass over all 1024 grid points clears
// the valid flags, during which no input beat is taken. Coefficients are not cleared.
`default_nettype none
module grid_coef_bilinear_interp (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  gcbi_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output gcbi_pkg::rsp_type  rsp_data,
   input  wire                psel,
   input  wire                penable,
   input  wire                pwrite,
   input  wire  [3:0]         paddr,
   input  wire  [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import gcbi_pkg::*;

   localparam logic [1:0] REG_GRID_LINES     = 2'd0;
   localparam logic [1:0] REG_GRID_SAMPLES   = 2'd1;
   localparam logic [1:0] REG_REGION_LINES   = 2'd2;
   localparam logic [1:0] REG_REGION_SAMPLES = 2'd3;

   cfg_type       cfg_ff, cfg_in;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          wr_en;

   // register write lands in the access phase
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            REG_GRID_LINES:     cfg_in.grid_lines     = pwdata[10:0];
            REG_GRID_SAMPLES:   cfg_in.grid_samples   = pwdata[10:0];
            REG_REGION_LINES:   cfg_in.region_lines   = pwdata[11:0];
            REG_REGION_SAMPLES: cfg_in.region_samples = pwdata[11:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_GRID_LINES:     prdata = {21'd0, cfg_ff.grid_lines};
         REG_GRID_SAMPLES:   prdata = {21'd0, cfg_ff.grid_samples};
         REG_REGION_LINES:   prdata = {20'd0, cfg_ff.region_lines};
         REG_REGION_SAMPLES: prdata = {20'd0, cfg_ff.region_samples};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_lines     <= 11'd32;
         cfg_ff.grid_samples   <= 11'd32;
         cfg_ff.region_lines   <= 12'd40;
         cfg_ff.region_samples <= 12'd40;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer: clear pass, load write, query steps, one result beat at a time
   gcbi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, dividers, weights, multiply-accumulate and output register
   gcbi_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_corners_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.valid_corners <= 3'd4))
      else $error("valid corner count above four");

   a_no_corner_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.valid_corners == 3'd0)) |-> (rsp_data.interp_value == '0))
      else $error("nonzero result with no valid corner");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.out_band < 3'(NUM_BANDS)) &&
                     (rsp_data.out_kind < 3'(NUM_KINDS))))
      else $error("band or kind code out of range");

   a_last_tag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> ((rsp_data.out_band == 3'(NUM_BANDS - 1)) &&
                                        (rsp_data.out_kind == 3'(NUM_KINDS - 1))))
      else $error("last flag on wrong result");
`endif

endmodule
`default_nettype wire

FILE: sv/gcbi_ctrl.sv
`default_nettype none
module gcbi_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire                     req_mode,
   output logic                    req_ready,
   input  gcbi_pkg::dp_status_type status,
   output gcbi_pkg::dp_cmd_type    cmd
);
   import gcbi_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DIV, S_CELL, S_WGT, S_WGT2, S_FRD, S_FCOL,
      S_ACC, S_DRN, S_FIN, S_PREP, S_QDIV, S_QEND, S_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [GRID_AW-1:0] clr_ff, clr_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [ENTRY_W-1:0] e_ff, e_in;
   logic [2:0]         band_ff, band_in, kind_ff, kind_in;
   logic               last_entry;

   assign last_entry = (e_ff == ENTRY_W'(PER_POINT - 1));
   assign req_ready  = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      cnt_in   = cnt_ff;
      e_in     = e_ff;
      band_in  = band_ff;
      kind_in  = kind_ff;
      cmd          = '0;
      cmd.clr_addr = clr_ff;
      cmd.corner   = cnt_ff[1:0];
      cmd.entry    = e_ff;
      cmd.band     = band_ff;
      cmd.kind     = kind_ff;
      cmd.last     = last_entry;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == GRID_AW'(MAX_GRID_POINTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_mode) begin
                  cmd.capture = 1'b1;
                  cnt_in      = '0;
                  state_in    = S_DIV;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) state_in = S_CELL;
         end
         S_CELL: begin
            cmd.locate = 1'b1;
            state_in   = S_WGT;
         end
         S_WGT: begin
            cmd.wgt  = 1'b1;
            state_in = S_WGT2;
         end
         S_WGT2: begin
            cmd.wgt2 = 1'b1;
            cnt_in   = '0;
            state_in = S_FRD;
         end
         S_FRD: begin
            cmd.flag_rd = 1'b1;
            state_in    = S_FCOL;
         end
         S_FCOL: begin
            cmd.flag_col = 1'b1;
            if (cnt_ff[1:0] == 2'd3) begin
               cnt_in   = '0;
               e_in     = '0;
               band_in  = '0;
               kind_in  = '0;
               state_in = S_ACC;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_FRD;
            end
         end
         S_ACC: begin
            cmd.acc_rd  = 1'b1;
            cmd.acc_clr = (cnt_ff == 5'd0);
            if (cnt_ff[1:0] == 2'd3) begin
               cnt_in   = '0;
               state_in = S_DRN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DRN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd1) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = status.need_div ? S_QDIV : S_EMIT;
         end
         S_QDIV: begin
            cmd.qdiv_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) state_in = S_QEND;
         end
         S_QEND: begin
            cmd.qend = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cnt_in   = '0;
               if (last_entry) begin
                  state_in = S_IDLE;
               end else begin
                  e_in     = e_ff + 1'b1;
                  state_in = S_ACC;
                  if (kind_ff == 3'(NUM_KINDS - 1)) begin
                     kind_in = '0;
                     band_in = band_ff + 1'b1;
                  end else begin
                     kind_in = kind_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         cnt_ff   <= '0;
         e_ff     <= '0;
         band_ff  <= '0;
         kind_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         cnt_ff   <= cnt_in;
         e_ff     <= e_in;
         band_ff  <= band_in;
         kind_ff  <= kind_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/gcbi_datapath.sv
`default_nettype none
module gcbi_datapath (
   input  wire                     clock,
   input  wire                     reset,
   input  gcbi_pkg::cfg_type       cfg,
   input  gcbi_pkg::req_type       req_data,
   input  gcbi_pkg::dp_cmd_type    cmd,
   output gcbi_pkg::dp_status_type status,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output gcbi_pkg::rsp_type       rsp_data
);
   import gcbi_pkg::*;

   localparam int WB = 30;

   typedef struct packed {
      logic [10:0]        lo;
      logic [10:0]        hi;
      logic signed [22:0] off;
   } axis_type;

   function automatic logic [12:0] div_bit(input logic [11:0] r, input logic b,
                                           input logic [11:0] d);
      logic [12:0] ext;
      logic        qb;
      ext = {r, b};
      qb  = (ext >= {1'b0, d});
      if (qb) ext = ext - {1'b0, d};
      return {ext[11:0], qb};
   endfunction

   function automatic axis_type axis_cell(input logic [31:0] q, input logic [10:0] count);
      logic signed [33:0] pos;
      logic [17:0]        p0w;
      logic [10:0]        p0, p1, lim;
      logic signed [34:0] diff;
      axis_type           a;
      pos = $signed({2'b00, q}) - 34'sd32768;
      lim = count - 11'd1;
      p0w = pos[33] ? 18'd0 : pos[33:16];
      if (p0w > {7'd0, lim}) p0 = lim;
      else p0 = p0w[10:0];
      p1 = p0 + 11'd1;
      if (p1 >= count) begin
         p1 = lim;
         if (p0 != 11'd0) p0 = p0 - 11'd1;
      end
      diff = $signed({pos[33], pos}) - $signed({8'd0, p0, 16'd0});
      if (diff < -35'sd2097152) a.off = -23'sd2097152;
      else if (diff > 35'sd2097151) a.off = 23'sd2097151;
      else a.off = diff[22:0];
      a.lo = p0;
      a.hi = p1;
      return a;
   endfunction

   function automatic logic [31:0] sat_coef(input logic neg, input logic [31:0] q,
                                            input logic ovf);
      logic [31:0] v;
      if (ovf) v = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else if (!neg) v = q[31] ? 32'h7FFF_FFFF : q;
      else v = (q > 32'h8000_0000) ? 32'h8000_0000 : (~q + 32'd1);
      return v;
   endfunction

   // effective configuration: zero acts as one
   logic [10:0] lines, cols;
   logic [11:0] reg_l, reg_s;
   assign lines = (cfg.grid_lines == '0) ? 11'd1 : cfg.grid_lines;
   assign cols  = (cfg.grid_samples == '0) ? 11'd1 : cfg.grid_samples;
   assign reg_l = (cfg.region_lines == '0) ? 12'd1 : cfg.region_lines;
   assign reg_s = (cfg.region_samples == '0) ? 12'd1 : cfg.region_samples;

   // memories
   logic [31:0]        coef_mem [COEF_DEPTH];
   logic               vmem     [MAX_GRID_POINTS];
   logic [31:0]        coef_q_ff;
   logic               vflag_q_ff;
   logic [COEF_AW-1:0] load_addr, rd_addr;
   logic               load_coef;

   // grid position dividers and cell
   logic [31:0]        lq_ff, sq_ff;
   logic [11:0]        lr_ff, sr_ff;
   logic [12:0]        lstep, sstep;
   axis_type           lax, sax;
   logic [10:0]        r0_ff, r1_ff, c0_ff, c1_ff;
   logic signed [22:0] dl_ff, ds_ff;
   logic signed [23:0] om_l, om_s;
   logic signed [47:0] wprod_ff;
   logic [47:0]        wmag;
   logic [31:0]        w0m;
   logic signed [WB-1:0] w0, w2;
   logic [21:0]        idx_ff [4];
   logic [21:0]        idx_sel;
   logic signed [WB-1:0] w_ff [4];
   logic [COEF_AW-1:0] base_ff [4];
   logic               vld_ff [4];

   // accumulation and result
   logic [2:0]         n_ff;
   logic signed [31:0] sum_w_ff;
   logic               s1_v_ff, s2_v_ff;
   logic [1:0]         s1_k_ff;
   logic signed [61:0] prod2_ff;
   logic signed [63:0] acc_ff;
   logic               a_neg_ff, b_neg_ff;
   logic [63:0]        a_mag_ff;
   logic [31:0]        b_mag_ff;
   logic [63:0]        dvd;
   logic [47:0]        qf;
   logic [32:0]        qr_ff, d2_ff;
   logic [31:0]        qn_ff;
   logic [33:0]        qext;
   logic               qbit, ovf_ff, q_neg_ff;
   logic [31:0]        res_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   assign load_coef = cmd.load && (req_data.band < 3'(NUM_BANDS)) &&
                      (req_data.kind < 3'(NUM_KINDS));
   assign load_addr = COEF_AW'(req_data.grid_index) * COEF_AW'(PER_POINT) +
                      COEF_AW'(req_data.band) * COEF_AW'(NUM_KINDS) +
                      COEF_AW'(req_data.kind);
   assign rd_addr   = base_ff[cmd.corner] + COEF_AW'(cmd.entry);
   assign idx_sel   = idx_ff[cmd.corner];

   always_ff @(posedge clock) begin
      if (load_coef) coef_mem[load_addr] <= req_data.coef_value;
      coef_q_ff <= coef_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) vmem[cmd.clr_addr] <= 1'b0;
      else if (cmd.load) vmem[req_data.grid_index] <= req_data.point_valid;
      if (cmd.flag_rd) vflag_q_ff <= vmem[idx_sel[GRID_AW-1:0]];
   end

   assign lstep = div_bit(lr_ff, lq_ff[31], reg_l);
   assign sstep = div_bit(sr_ff, sq_ff[31], reg_s);
   assign lax   = axis_cell(lq_ff, lines);
   assign sax   = axis_cell(sq_ff, cols);
   assign om_l  = 24'sd65536 - {dl_ff[22], dl_ff};
   assign om_s  = 24'sd65536 - {ds_ff[22], ds_ff};
   assign wmag  = wprod_ff[47] ? (~wprod_ff + 48'd1) : wprod_ff;
   assign w0m   = 32'((wmag + 48'd32768) >> 16);
   assign w0    = wprod_ff[47] ? -$signed(w0m[WB-1:0]) : $signed(w0m[WB-1:0]);
   assign w2    = WB'(65536) - WB'(ds_ff) - w0;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lq_ff <= {req_data.pixel_line, 16'd0};
         sq_ff <= {req_data.pixel_sample, 16'd0};
         lr_ff <= '0;
         sr_ff <= '0;
      end else if (cmd.div_step) begin
         lq_ff <= {lq_ff[30:0], lstep[0]};
         sq_ff <= {sq_ff[30:0], sstep[0]};
         lr_ff <= lstep[12:1];
         sr_ff <= sstep[12:1];
      end
      if (cmd.locate) begin
         r0_ff <= lax.lo;
         r1_ff <= lax.hi;
         dl_ff <= lax.off;
         c0_ff <= sax.lo;
         c1_ff <= sax.hi;
         ds_ff <= sax.off;
      end
      if (cmd.wgt) begin
         wprod_ff  <= om_l * om_s;
         idx_ff[0] <= 22'(r0_ff) * 22'(cols) + 22'(c0_ff);
         idx_ff[1] <= 22'(r0_ff) * 22'(cols) + 22'(c1_ff);
         idx_ff[2] <= 22'(r1_ff) * 22'(cols) + 22'(c0_ff);
         idx_ff[3] <= 22'(r1_ff) * 22'(cols) + 22'(c1_ff);
      end
      if (cmd.wgt2) begin
         // weights sum to exactly one by construction
         w_ff[0] <= w0;
         w_ff[1] <= WB'(65536) - WB'(dl_ff) - w0;
         w_ff[2] <= w2;
         w_ff[3] <= WB'(dl_ff) - w2;
         for (int k = 0; k < 4; k++) begin
            base_ff[k] <= COEF_AW'(idx_ff[k][GRID_AW-1:0]) * COEF_AW'(PER_POINT);
         end
      end
      if (cmd.flag_col) begin
         vld_ff[cmd.corner] <= vflag_q_ff && (idx_sel < 22'(MAX_GRID_POINTS));
      end
   end

   // multiply-accumulate pipeline: read, multiply, add
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.acc_rd;
         s2_v_ff <= s1_v_ff && vld_ff[s1_k_ff];
      end
      s1_k_ff  <= cmd.corner;
      prod2_ff <= $signed(coef_q_ff) * w_ff[s1_k_ff];
      if (cmd.acc_clr) begin
         acc_ff   <= '0;
         n_ff     <= 3'(vld_ff[0]) + 3'(vld_ff[1]) + 3'(vld_ff[2]) + 3'(vld_ff[3]);
         sum_w_ff <= (vld_ff[0] ? 32'(w_ff[0]) : 32'sd0) +
                     (vld_ff[1] ? 32'(w_ff[1]) : 32'sd0) +
                     (vld_ff[2] ? 32'(w_ff[2]) : 32'sd0) +
                     (vld_ff[3] ? 32'(w_ff[3]) : 32'sd0);
      end else if (s2_v_ff) begin
         acc_ff <= acc_ff + 64'(prod2_ff);
      end
   end

   assign status.need_div = (n_ff != 3'd0) && (n_ff != 3'd4) && (sum_w_ff != 32'sd0);

   assign dvd  = {a_mag_ff[62:0], 1'b0} + {32'd0, b_mag_ff};
   assign qf   = 48'((a_mag_ff + 64'd32768) >> 16);
   assign qext = {qr_ff, qn_ff[31]};
   assign qbit = (qext >= {1'b0, d2_ff});

   // rounded quotient: (2|a| + |b|) / (2|b|), one bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         a_neg_ff <= acc_ff[63];
         a_mag_ff <= acc_ff[63] ? (~acc_ff + 64'd1) : acc_ff;
         b_neg_ff <= sum_w_ff[31];
         b_mag_ff <= sum_w_ff[31] ? (~sum_w_ff + 32'd1) : sum_w_ff;
      end
      if (cmd.prep) begin
         if (n_ff == 3'd0) begin
            res_ff <= '0;
         end else if (n_ff == 3'd4) begin
            res_ff <= sat_coef(a_neg_ff, qf[31:0], |qf[47:32]);
         end else if (sum_w_ff == 32'sd0) begin
            res_ff <= (a_mag_ff == '0) ? 32'd0 :
                      (a_neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF);
         end
         ovf_ff   <= ({1'b0, dvd[63:32]} >= {b_mag_ff, 1'b0});
         qr_ff    <= {1'b0, dvd[63:32]};
         qn_ff    <= dvd[31:0];
         d2_ff    <= {b_mag_ff, 1'b0};
         q_neg_ff <= a_neg_ff ^ b_neg_ff;
      end else if (cmd.qdiv_step) begin
         qr_ff <= qbit ? 33'(qext - {1'b0, d2_ff}) : qext[32:0];
         qn_ff <= {qn_ff[30:0], qbit};
      end
      if (cmd.qend) res_ff <= sat_coef(q_neg_ff, qn_ff, ovf_ff);
   end

   // output register: hold a beat until taken
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
      if (cmd.emit) begin
         rsp_data_ff.out_band      <= cmd.band;
         rsp_data_ff.out_kind      <= cmd.kind;
         rsp_data_ff.interp_value  <= res_ff;
         rsp_data_ff.valid_corners <= n_ff;
         rsp_data_ff.last          <= cmd.last;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule
`default_nettype wire
